// File: rtl/interval_set_tracker_core_macros.svh
// Assertion macros shared by the interval set tracker checker.
// Depends on nothing; take in by `include.
`ifndef INTERVAL_SET_TRACKER_CORE_MACROS_SVH
`define INTERVAL_SET_TRACKER_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset
`define IST_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("interval set tracker: assertion failed");

// Next-cycle implication, disabled during reset
`define IST_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("interval set tracker: assertion failed");

`endif

// File: rtl/ist_pkg.sv
// Shared types and constants of the interval set tracker.
// No dependencies; used by the core and its checker.
package ist_pkg;

   localparam int MAX_INTERVALS_DEFAULT = 64;
   localparam int COORD_BITS_DEFAULT    = 32;
   localparam int FIELD_BITS            = 32;
   localparam int COUNT_FIELD_BITS      = 7;

   typedef enum logic [1:0] {
      OP_ADD    = 2'd0,
      OP_REMOVE = 2'd1,
      OP_QUERY  = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_EVAL,
      ST_EMIT2,
      ST_FINAL,
      ST_DONE
   } state_type;

endpackage

// File: rtl/interval_set_tracker_core.sv
// Interval set tracker: keeps a sorted table of disjoint, non-touching closed
// intervals in a double-banked RAM and applies add, remove and query requests
// to the half-open range [start, stop). A request walks the stored table one
// entry at a time through the single RAM read port, reading then evaluating
// each stored interval and writing one extra entry for a split or for the
// merged range placed ahead of a later interval; an empty range or an
// unknown operation goes straight to the response.
// The new table is built in the idle bank and swapped in only if it fits, so
// a refused add or split leaves the table as it was and raises overflow.
// Depends on ist_pkg and ist_ram.
module interval_set_tracker_core #(
   parameter int MAX_INTERVALS = ist_pkg::MAX_INTERVALS_DEFAULT,
   parameter int COORD_BITS    = ist_pkg::COORD_BITS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [1:0]                           req_operation,
   input  logic [ist_pkg::FIELD_BITS-1:0]       req_range_start,
   input  logic [ist_pkg::FIELD_BITS-1:0]       req_range_stop,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_covered,
   output logic                                 rsp_overflow,
   output logic [ist_pkg::COUNT_FIELD_BITS-1:0] rsp_interval_count
);

   localparam int CB      = COORD_BITS;
   localparam int IW      = $clog2(MAX_INTERVALS);
   localparam int CNW     = $clog2(MAX_INTERVALS + 1);
   localparam int NW      = $clog2(MAX_INTERVALS + 2);
   localparam int RDEPTH  = 2 * (2 ** IW);
   localparam int WB      = ist_pkg::FIELD_BITS + CB;
   localparam int OCW     = ist_pkg::COUNT_FIELD_BITS;
   localparam int PADW    = (OCW > CNW) ? OCW : CNW;

   ist_pkg::state_type state_ff, state_in;
   ist_pkg::op_type    op_ff, op_in;
   logic               doit_ff, doit_in;
   logic [CB-1:0]      s_ff, s_in, e_ff, e_in;
   logic [CB-1:0]      lo_ff, lo_in, hi_ff, hi_in;
   logic [CB-1:0]      pf_ff, pf_in, pl_ff, pl_in;
   logic               placed_ff, placed_in;
   logic               covered_ff, covered_in;
   logic [NW-1:0]      n_ff, n_in;
   logic [CNW-1:0]     i_ff, i_in;
   logic [CNW-1:0]     count_ff, count_in;
   logic               bank_ff, bank_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_cov_ff, rsp_cov_in;
   logic               rsp_ovf_ff, rsp_ovf_in;
   logic [OCW-1:0]     rsp_cnt_ff, rsp_cnt_in;

   logic [WB-1:0]      start_wide, stop_wide;
   logic [CB-1:0]      start_c, stop_c;
   logic [2*CB-1:0]    rd_data;
   logic [CB-1:0]      f_c, l_c;
   logic               we_c, re_c;
   logic [CB-1:0]      wf_c, wl_c;
   logic               ovf_c;
   logic [PADW-1:0]    cnt_pad;

   // mask request coordinates to the coordinate width
   assign start_wide = {{CB{1'b0}}, req_range_start};
   assign stop_wide  = {{CB{1'b0}}, req_range_stop};
   assign start_c    = start_wide[CB-1:0];
   assign stop_c     = stop_wide[CB-1:0];

   assign f_c = rd_data[2*CB-1:CB];
   assign l_c = rd_data[CB-1:0];

   assign ovf_c = doit_ff && (op_ff == ist_pkg::OP_ADD || op_ff == ist_pkg::OP_REMOVE)
                  && (n_ff > NW'(MAX_INTERVALS));

   ist_ram #(
      .WIDTH (2 * CB),
      .DEPTH (RDEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (we_c && (n_ff < NW'(MAX_INTERVALS))),
      .wr_addr ({~bank_ff, n_ff[IW-1:0]}),
      .wr_data ({wf_c, wl_c}),
      .rd_en   (re_c),
      .rd_addr ({bank_ff, i_ff[IW-1:0]}),
      .rd_data (rd_data)
   );

   // state and control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ist_pkg::ST_IDLE;
         count_ff     <= '0;
         bank_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         bank_ff      <= bank_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working registers of the current request
   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      doit_ff    <= doit_in;
      s_ff       <= s_in;
      e_ff       <= e_in;
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      pf_ff      <= pf_in;
      pl_ff      <= pl_in;
      placed_ff  <= placed_in;
      covered_ff <= covered_in;
      n_ff       <= n_in;
      i_ff       <= i_in;
      rsp_cov_ff <= rsp_cov_in;
      rsp_ovf_ff <= rsp_ovf_in;
      rsp_cnt_ff <= rsp_cnt_in;
   end

   // sequence the table walk and build the new table
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      doit_in      = doit_ff;
      s_in         = s_ff;
      e_in         = e_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      pf_in        = pf_ff;
      pl_in        = pl_ff;
      placed_in    = placed_ff;
      covered_in   = covered_ff;
      i_in         = i_ff;
      count_in     = count_ff;
      bank_in      = bank_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_cov_in   = rsp_cov_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      rsp_cnt_in   = rsp_cnt_ff;
      we_c         = 1'b0;
      re_c         = 1'b0;
      wf_c         = f_c;
      wl_c         = l_c;
      cnt_pad      = '0;

      // drop the response once taken
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ist_pkg::ST_IDLE: begin
            if (req_valid) begin
               op_in      = ist_pkg::op_type'(req_operation);
               doit_in    = start_c < stop_c;
               s_in       = start_c;
               e_in       = stop_c - 1'b1;
               lo_in      = start_c;
               hi_in      = stop_c - 1'b1;
               placed_in  = 1'b0;
               covered_in = 1'b0;
               i_in       = '0;
               if (start_c < stop_c && req_operation != ist_pkg::OP_NONE) begin
                  state_in = ist_pkg::ST_READ;
               end else begin
                  state_in = ist_pkg::ST_DONE;
               end
            end
         end

         ist_pkg::ST_READ: begin
            if (i_ff == count_ff) begin
               if (op_ff == ist_pkg::OP_ADD && !placed_ff) begin
                  state_in = ist_pkg::ST_FINAL;
               end else begin
                  state_in = ist_pkg::ST_DONE;
               end
            end else begin
               re_c     = 1'b1;
               state_in = ist_pkg::ST_EVAL;
            end
         end

         ist_pkg::ST_EVAL: begin
            i_in     = i_ff + 1'b1;
            state_in = ist_pkg::ST_READ;
            unique case (op_ff)
               ist_pkg::OP_ADD: begin
                  if (({1'b0, l_c} + 1'b1) < {1'b0, s_ff}) begin
                     we_c = 1'b1;
                  end else if ({1'b0, f_c} > ({1'b0, e_ff} + 1'b1)) begin
                     we_c = 1'b1;
                     if (!placed_ff) begin
                        // place the merged range, then the stored one
                        wf_c      = lo_ff;
                        wl_c      = hi_ff;
                        placed_in = 1'b1;
                        pf_in     = f_c;
                        pl_in     = l_c;
                        state_in  = ist_pkg::ST_EMIT2;
                     end
                  end else begin
                     if (f_c < lo_ff) lo_in = f_c;
                     if (l_c > hi_ff) hi_in = l_c;
                  end
               end
               ist_pkg::OP_REMOVE: begin
                  if (l_c < s_ff || f_c > e_ff) begin
                     we_c = 1'b1;
                  end else if (f_c < s_ff) begin
                     we_c = 1'b1;
                     wl_c = s_ff - 1'b1;
                     if (l_c > e_ff) begin
                        pf_in    = e_ff + 1'b1;
                        pl_in    = l_c;
                        state_in = ist_pkg::ST_EMIT2;
                     end
                  end else if (l_c > e_ff) begin
                     we_c = 1'b1;
                     wf_c = e_ff + 1'b1;
                  end
               end
               ist_pkg::OP_QUERY: begin
                  if (f_c <= s_ff && l_c >= e_ff) covered_in = 1'b1;
               end
               default: begin
               end
            endcase
         end

         ist_pkg::ST_EMIT2: begin
            we_c     = 1'b1;
            wf_c     = pf_ff;
            wl_c     = pl_ff;
            state_in = ist_pkg::ST_READ;
         end

         ist_pkg::ST_FINAL: begin
            we_c      = 1'b1;
            wf_c      = lo_ff;
            wl_c      = hi_ff;
            placed_in = 1'b1;
            state_in  = ist_pkg::ST_DONE;
         end

         ist_pkg::ST_DONE: begin
            // commit and report once the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               if (doit_ff && !ovf_c
                   && (op_ff == ist_pkg::OP_ADD || op_ff == ist_pkg::OP_REMOVE)) begin
                  count_in = n_ff[CNW-1:0];
                  bank_in  = ~bank_ff;
               end
               cnt_pad[CNW-1:0] = count_in;
               rsp_valid_in = 1'b1;
               rsp_cov_in   = covered_ff;
               rsp_ovf_in   = ovf_c;
               rsp_cnt_in   = cnt_pad[OCW-1:0];
               state_in     = ist_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = ist_pkg::ST_IDLE;
         end
      endcase
   end

   // count entries of the new table, holding at one past capacity
   always_comb begin
      n_in = n_ff;
      if (state_ff == ist_pkg::ST_IDLE) begin
         n_in = '0;
      end else if (we_c && n_ff <= NW'(MAX_INTERVALS)) begin
         n_in = n_ff + 1'b1;
      end
   end

   assign req_ready          = (state_ff == ist_pkg::ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_covered        = rsp_cov_ff;
   assign rsp_overflow       = rsp_ovf_ff;
   assign rsp_interval_count = rsp_cnt_ff;

endmodule

// File: rtl/ist_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module ist_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port, then registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/ist_checker.sv
// Port-level checker for the interval set tracker, bound to the top level.
// Depends on ist_pkg and interval_set_tracker_core_macros.svh.
`include "interval_set_tracker_core_macros.svh"

module ist_checker #(
   parameter int MAX_INTERVALS = ist_pkg::MAX_INTERVALS_DEFAULT
) (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_ready,
   input logic                                 rsp_valid,
   input logic                                 rsp_ready,
   input logic                                 rsp_covered,
   input logic                                 rsp_overflow,
   input logic [ist_pkg::COUNT_FIELD_BITS-1:0] rsp_interval_count
);

   localparam int CW = ist_pkg::COUNT_FIELD_BITS;

   // a taken request keeps the input closed while it is worked on
   `IST_ASSERT_NXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)

   // covered and overflow never come together
   `IST_ASSERT_IMP(a_flags_exclusive, clock, reset, rsp_valid, !(rsp_covered && rsp_overflow))

   // a refused request leaves a full table
   `IST_ASSERT_IMP(a_ovf_full, clock, reset,
      rsp_valid && rsp_overflow && MAX_INTERVALS < 128, rsp_interval_count == CW'(MAX_INTERVALS))

   // the count never exceeds capacity
   `IST_ASSERT_IMP(a_count_bound, clock, reset, rsp_valid && MAX_INTERVALS < 128,
      rsp_interval_count <= CW'(MAX_INTERVALS))

   // a waiting response holds
   `IST_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_interval_count) && $stable(rsp_overflow))

endmodule

bind interval_set_tracker_core ist_checker #(
   .MAX_INTERVALS (MAX_INTERVALS)
) u_ist_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_ready          (req_ready),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_covered        (rsp_covered),
   .rsp_overflow       (rsp_overflow),
   .rsp_interval_count (rsp_interval_count)
);

// File: verif/tb.sv
// Testbench for interval_set_tracker_core: directed table then random requests,
// each response checked against an in-bench interval table predictor.
// Depends on ist_pkg and the core RTL.
`timescale 1ns / 100ps

module tb;

   localparam int CAP = 64;
   localparam int LIMIT = 2000000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_operation = ist_pkg::OP_ADD;
   logic [31:0] req_range_start = '0;
   logic [31:0] req_range_stop = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_covered;
   logic        rsp_overflow;
   logic [6:0]  rsp_interval_count;

   typedef struct packed {
      logic       covered;
      logic       overflow;
      logic [6:0] count;
   } answer_type;

   typedef struct {
      ist_pkg::op_type op;
      logic [31:0]     start;
      logic [31:0]     stop;
      bit              typed;
      answer_type      want;
   } row_type;

   answer_type  answers_due[$];
   logic [32:0] span_lo[CAP];
   logic [32:0] span_hi[CAP];
   logic [32:0] build_lo[CAP+1];
   logic [32:0] build_hi[CAP+1];
   int          span_count = 0;
   int          build_count;
   int          mismatches = 0;
   int          cycles = 0;
   bit          hold_off = 0;

   interval_set_tracker_core DUT (.*);

   // Free-running clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Bound the run
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      mismatches++;
   endtask

   function automatic void put_span(input logic [32:0] lo, input logic [32:0] hi);
      if (build_count < CAP + 1) begin
         build_lo[build_count] = lo;
         build_hi[build_count] = hi;
         build_count++;
      end
   endfunction

   // Apply one request to the predicted table and give the expected response
   function automatic answer_type predict_answer(input ist_pkg::op_type op,
                                                 input logic [31:0] a,
                                                 input logic [31:0] b);
      answer_type  r;
      logic [32:0] s, e, lo, hi;
      bit          placed;
      r = '0;
      s = {1'b0, a};
      e = {1'b0, b} - 33'd1;
      build_count = 0;
      if (a < b && (op == ist_pkg::OP_ADD || op == ist_pkg::OP_REMOVE)) begin
         placed = 0;
         lo = s;
         hi = e;
         for (int i = 0; i < span_count; i++) begin
            if (op == ist_pkg::OP_ADD) begin
               if (span_hi[i] + 1 < s) put_span(span_lo[i], span_hi[i]);
               else if (span_lo[i] > e + 1) begin
                  if (!placed) begin
                     put_span(lo, hi);
                     placed = 1;
                  end
                  put_span(span_lo[i], span_hi[i]);
               end else begin
                  if (span_lo[i] < lo) lo = span_lo[i];
                  if (span_hi[i] > hi) hi = span_hi[i];
               end
            end else if (span_hi[i] < s || span_lo[i] > e) begin
               put_span(span_lo[i], span_hi[i]);
            end else begin
               if (span_lo[i] < s) put_span(span_lo[i], s - 1);
               if (span_hi[i] > e) put_span(e + 1, span_hi[i]);
            end
         end
         if (op == ist_pkg::OP_ADD && !placed) put_span(lo, hi);
         if (build_count > CAP) r.overflow = 1'b1;
         else begin
            for (int i = 0; i < build_count; i++) begin
               span_lo[i] = build_lo[i];
               span_hi[i] = build_hi[i];
            end
            span_count = build_count;
         end
      end else if (a < b && op == ist_pkg::OP_QUERY) begin
         for (int i = 0; i < span_count; i++)
            if (span_lo[i] <= s && span_hi[i] >= e) r.covered = 1'b1;
      end
      r.count = span_count[6:0];
      return r;
   endfunction

   // Offer one request, holding it until accepted
   task automatic send_request(input ist_pkg::op_type op, input logic [31:0] a,
                               input logic [31:0] b, input bit typed,
                               input answer_type want);
      answer_type got;
      int         idle;
      idle = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16) : 0;
      if (idle > 0) begin
         req_valid <= 1'b0;
         repeat (idle) @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_operation   <= op;
      req_range_start <= a;
      req_range_stop  <= b;
      do @(posedge clock); while (!req_ready);
      got = predict_answer(op, a, b);
      if (typed && got != want) report("typed row vs predictor", got, want);
      answers_due.push_back(got);
      @(negedge clock);
   endtask

   // Receiver: random stalls, one long hold-off
   initial begin
      int idle;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_off) begin
            rsp_ready <= 1'b0;
            repeat (3000) @(negedge clock);
            hold_off = 0;
         end else begin
            idle = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 16) : 0;
            if (idle > 0) begin
               rsp_ready <= 1'b0;
               repeat (idle) @(negedge clock);
            end
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   // Compare each response with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (answers_due.size() == 0) report("unexpected response", 1, 0);
         else begin
            answer_type w;
            w = answers_due.pop_front();
            if (rsp_covered !== w.covered) report("covered", rsp_covered, w.covered);
            if (rsp_overflow !== w.overflow) report("overflow", rsp_overflow, w.overflow);
            if (rsp_interval_count !== w.count)
               report("interval_count", rsp_interval_count, w.count);
         end
      end
   end

   // Stimulus
   initial begin
      row_type          rows[$];
      logic [31:0]      a, b, base, w;
      ist_pkg::op_type  op;
      int               mode;
      rows = '{
         '{ist_pkg::OP_QUERY,  32'd0,        32'd1,          1,
           answer_type'{1'b0, 1'b0, 7'd0}},
         '{ist_pkg::OP_REMOVE, 32'd0,        32'hFFFF_FFFF,  1,
           answer_type'{1'b0, 1'b0, 7'd0}},
         '{ist_pkg::OP_ADD,    32'd5,        32'd5,          1,
           answer_type'{1'b0, 1'b0, 7'd0}},
         '{ist_pkg::OP_ADD,    32'd9,        32'd3,          1,
           answer_type'{1'b0, 1'b0, 7'd0}},
         '{ist_pkg::OP_ADD,    32'd0,        32'd1,          1,
           answer_type'{1'b0, 1'b0, 7'd1}},
         '{ist_pkg::OP_ADD,    32'hFFFF_FFFE, 32'hFFFF_FFFF, 1,
           answer_type'{1'b0, 1'b0, 7'd2}},
         '{ist_pkg::OP_QUERY,  32'hFFFF_FFFE, 32'hFFFF_FFFF, 1,
           answer_type'{1'b1, 1'b0, 7'd2}},
         '{ist_pkg::OP_NONE,   32'd0,        32'd10,         1,
           answer_type'{1'b0, 1'b0, 7'd2}},
         '{ist_pkg::OP_ADD,    32'd10,       32'd20,         0, '0},
         '{ist_pkg::OP_ADD,    32'd20,       32'd30,         0, '0},
         '{ist_pkg::OP_ADD,    32'd1,        32'd10,         0, '0},
         '{ist_pkg::OP_QUERY,  32'd0,        32'd30,         0, '0},
         '{ist_pkg::OP_QUERY,  32'd0,        32'd31,         0, '0},
         '{ist_pkg::OP_REMOVE, 32'd12,       32'd15,         0, '0},
         '{ist_pkg::OP_REMOVE, 32'd0,        32'd13,         0, '0},
         '{ist_pkg::OP_QUERY,  32'd15,       32'd30,         0, '0},
         '{ist_pkg::OP_REMOVE, 32'd29,       32'd40,         0, '0},
         '{ist_pkg::OP_QUERY,  32'd20,       32'd29,         0, '0},
         '{ist_pkg::OP_QUERY,  32'd7,        32'd7,          0, '0},
         '{ist_pkg::OP_NONE,   32'hFFFF_FFFF, 32'd0,         0, '0},
         '{ist_pkg::OP_ADD,    32'd0,        32'hFFFF_FFFF,  0, '0},
         '{ist_pkg::OP_REMOVE, 32'd0,        32'hFFFF_FFFF,  0, '0}
      };
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      foreach (rows[i])
         send_request(rows[i].op, rows[i].start, rows[i].stop, rows[i].typed, rows[i].want);
      // Fill the table to capacity with isolated points, then force overflow
      for (int i = 0; i < CAP; i++) begin
         if (i == 20) hold_off = 1;
         send_request(ist_pkg::OP_ADD, 32'd4 * i + 100, 32'd4 * i + 101, 0, '0);
      end
      send_request(ist_pkg::OP_ADD, 32'd2, 32'd3, 0, '0);
      send_request(ist_pkg::OP_REMOVE, 32'd104, 32'd104 + 1, 0, '0);
      send_request(ist_pkg::OP_REMOVE, 32'd200, 32'd200 + 1, 0, '0);
      send_request(ist_pkg::OP_REMOVE, 32'd100, 32'd101, 0, '0);
      send_request(ist_pkg::OP_ADD, 32'd0, 32'd50, 0, '0);
      send_request(ist_pkg::OP_REMOVE, 32'd300, 32'd400, 0, '0);
      // Random: mostly small window so ranges collide, some full-width values
      for (int n = 0; n < 560; n++) begin
         mode = $urandom_range(0, 9);
         op = ist_pkg::op_type'($urandom_range(0, 9) < 4 ? ist_pkg::OP_ADD
                                                          : $urandom_range(0, 3));
         base = ($urandom_range(0, 1)) ? 32'd0 : 32'hFFFF_FC00;
         if (mode < 8) begin
            a = base + $urandom_range(0, 1000);
            w = (mode < 6) ? $urandom_range(1, 12) : $urandom_range(1, 200);
            b = a + w;
            if (b < a) b = 32'hFFFF_FFFF;
         end else begin
            a = $urandom;
            b = (mode == 8) ? $urandom : a;
         end
         send_request(op, a, b, 0, '0);
      end
      req_valid <= 1'b0;
      while (answers_due.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (mismatches == 0) $display("ALL CHECKS PASSED");
      else $display("CHECKS FAILED");
      $finish;
   end
endmodule
